// ===== sv/pwmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmt_pkg: shared types and constants for the four-channel PWM timer
// Opcodes, register map, default sizes and the word formats passed
// between the timer core and the result register.
// ----------------------------------------------------------------------------
package pwmt_pkg;

  // Default sizes
  localparam int DEF_COUNT_WIDTH  = 32;
  localparam int DEF_NUM_CHANNELS = 4;
  localparam int MAX_CHANNELS     = 4;
  localparam int PRESCALE_WIDTH   = 16;
  localparam int DATA_WIDTH       = 32;
  localparam int CHAN_BITS_WIDTH  = 16;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } opcode_t;

  // Register map
  localparam logic [3:0] REG_CTRL   = 4'd0;
  localparam logic [3:0] REG_STATUS = 4'd1;
  localparam logic [3:0] REG_EVENT  = 4'd2;
  localparam logic [3:0] REG_CHAN   = 4'd3;
  localparam logic [3:0] REG_COUNT  = 4'd4;
  localparam logic [3:0] REG_PSC    = 4'd5;
  localparam logic [3:0] REG_RELOAD = 4'd6;
  localparam logic [3:0] REG_CMP1   = 4'd7;

  // Core result, before channel levels are attached
  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  update_event;
  } core_res_t;

  // Full result word held in the output register
  typedef struct packed {
    logic [DATA_WIDTH-1:0]   read_data;
    logic [MAX_CHANNELS-1:0] pwm_out;
    logic                    update_event;
  } result_t;

endpackage

// ===== sv/pwmt_core.sv =====
// ----------------------------------------------------------------------------
// pwmt_core: timer state and register file
// Holds prescaler, counter, reload, compare preload/active copies and
// control bits. Computes the next state and the read/event result of
// each accepted word in one pass.
// ----------------------------------------------------------------------------
module pwmt_core import pwmt_pkg::*; #(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   fire,
  input  logic [1:0]                             opcode,
  input  logic [3:0]                             reg_index,
  input  logic [DATA_WIDTH-1:0]                  write_data,
  output core_res_t                              res,
  output logic [COUNT_WIDTH-1:0]                 count_view,
  output logic [NUM_CHANNELS-1:0][DATA_WIDTH-1:0] cmp_view,
  output logic [CHAN_BITS_WIDTH-1:0]             chan_view
);

  logic [PRESCALE_WIDTH-1:0] psc_cnt, psc_cnt_next;
  logic [PRESCALE_WIDTH-1:0] psc_pre, psc_pre_next;
  logic [PRESCALE_WIDTH-1:0] psc_act, psc_act_next;
  logic [COUNT_WIDTH-1:0]    cnt, cnt_next;
  logic [COUNT_WIDTH-1:0]    reload, reload_next;
  logic [NUM_CHANNELS-1:0][DATA_WIDTH-1:0] cmp_pre, cmp_pre_next;
  logic [NUM_CHANNELS-1:0][DATA_WIDTH-1:0] cmp_act, cmp_act_next;
  logic [CHAN_BITS_WIDTH-1:0] chan_bits, chan_bits_next;
  logic                      cnt_en, cnt_en_next;
  logic                      upd_flag, upd_flag_next;
  logic                      upd;
  logic [DATA_WIDTH-1:0]     rd;

  // Next state and result for the word at the input
  always_comb begin
    psc_cnt_next   = psc_cnt;
    psc_pre_next   = psc_pre;
    psc_act_next   = psc_act;
    cnt_next       = cnt;
    reload_next    = reload;
    cmp_pre_next   = cmp_pre;
    cmp_act_next   = cmp_act;
    chan_bits_next = chan_bits;
    cnt_en_next    = cnt_en;
    upd_flag_next  = upd_flag;
    upd            = 1'b0;
    rd             = '0;
    if (fire) begin
      case (opcode_t'(opcode))
        OP_TICK: begin
          if (cnt_en) begin
            if (psc_cnt < psc_act) begin
              psc_cnt_next = psc_cnt + 1'b1;
            end else begin
              psc_cnt_next = '0;
              if (cnt == reload) begin
                cnt_next = '0;
                upd      = 1'b1;
              end else begin
                cnt_next = cnt + 1'b1;
              end
            end
          end
        end
        OP_WRITE: begin
          case (reg_index)
            REG_CTRL:   cnt_en_next = write_data[0];
            REG_STATUS: if (!write_data[0]) upd_flag_next = 1'b0;
            REG_EVENT: begin
              if (write_data[0]) begin
                psc_cnt_next = '0;
                cnt_next     = '0;
                upd          = 1'b1;
              end
            end
            REG_CHAN:   chan_bits_next = write_data[CHAN_BITS_WIDTH-1:0];
            REG_COUNT:  cnt_next       = write_data[COUNT_WIDTH-1:0];
            REG_PSC:    psc_pre_next   = write_data[PRESCALE_WIDTH-1:0];
            REG_RELOAD: reload_next    = write_data[COUNT_WIDTH-1:0];
            default: begin
              for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (reg_index == REG_CMP1 + 4'(k)) cmp_pre_next[k] = write_data;
              end
            end
          endcase
        end
        OP_READ: begin
          case (reg_index)
            REG_CTRL:   rd = DATA_WIDTH'(cnt_en);
            REG_STATUS: rd = DATA_WIDTH'(upd_flag);
            REG_EVENT:  rd = '0;
            REG_CHAN:   rd = DATA_WIDTH'(chan_bits);
            REG_COUNT:  rd = DATA_WIDTH'(cnt);
            REG_PSC:    rd = DATA_WIDTH'(psc_pre);
            REG_RELOAD: rd = DATA_WIDTH'(reload);
            default: begin
              for (int k = 0; k < NUM_CHANNELS; k++) begin
                if (reg_index == REG_CMP1 + 4'(k)) rd = cmp_pre[k];
              end
            end
          endcase
        end
        default: ;
      endcase
    end
    // Update event: load shadows and set the flag
    if (upd) begin
      psc_act_next  = psc_pre;
      cmp_act_next  = cmp_pre;
      upd_flag_next = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      psc_cnt   <= '0;
      psc_pre   <= '0;
      psc_act   <= '0;
      cnt       <= '0;
      reload    <= '1;
      cmp_pre   <= '0;
      cmp_act   <= '0;
      chan_bits <= '0;
      cnt_en    <= 1'b0;
      upd_flag  <= 1'b0;
    end else begin
      psc_cnt   <= psc_cnt_next;
      psc_pre   <= psc_pre_next;
      psc_act   <= psc_act_next;
      cnt       <= cnt_next;
      reload    <= reload_next;
      cmp_pre   <= cmp_pre_next;
      cmp_act   <= cmp_act_next;
      chan_bits <= chan_bits_next;
      cnt_en    <= cnt_en_next;
      upd_flag  <= upd_flag_next;
    end
  end

  // Post-update view for the channel compare
  assign res.read_data    = rd;
  assign res.update_event = upd;
  assign count_view       = cnt_next;
  assign cmp_view         = cmp_act_next;
  assign chan_view        = chan_bits_next;

endmodule

// ===== sv/pwmt_channels.sv =====
// ----------------------------------------------------------------------------
// pwmt_channels: PWM mode 1 output stage
// Per channel: reference is counter < compare, flipped by polarity,
// gated by enable. Channels past NUM_CHANNELS drive 0.
// ----------------------------------------------------------------------------
module pwmt_channels import pwmt_pkg::*; #(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic [COUNT_WIDTH-1:0]                  count_view,
  input  logic [NUM_CHANNELS-1:0][DATA_WIDTH-1:0] cmp_view,
  input  logic [CHAN_BITS_WIDTH-1:0]              chan_view,
  output logic [MAX_CHANNELS-1:0]                 pwm
);

  logic [DATA_WIDTH-1:0] count_ext;

  assign count_ext = DATA_WIDTH'(count_view);

  // One comparator per channel
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_chan
    if (i < NUM_CHANNELS) begin : g_on
      logic ref_lvl;
      assign ref_lvl = count_ext < cmp_view[i];
      assign pwm[i]  = chan_view[4*i] & (ref_lvl ^ chan_view[4*i+1]);
    end else begin : g_off
      assign pwm[i] = 1'b0;
    end
  end

endmodule

// ===== sv/pwmt_out_reg.sv =====
// ----------------------------------------------------------------------------
// pwmt_out_reg: result register with valid/ready
// Loads a result word on every accepted input word; holds it until the
// downstream side takes it. Input ready is open while the slot is empty
// or being drained in the same cycle.
// ----------------------------------------------------------------------------
module pwmt_out_reg import pwmt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t res_in,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t res_out
);

  logic fire;

  assign in_ready = !rst && (!out_valid || out_ready);
  assign fire     = in_valid && in_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (fire) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== sv/pwm_timer_four_channel.sv =====
// ----------------------------------------------------------------------------
// pwm_timer_four_channel: four-channel up-counting PWM timer
// An accepted word's result is in the output register in the cycle after it is accepted.
// Throughput: one word per cycle while the result register is empty or drained;
// the state update, counter compare and wrap all settle in a single pass before the result register.
// Reset (rst, synchronous): counter and prescaler cleared, reload all ones,
// compares and channel bits zero, counting disabled, no result pending.
// ----------------------------------------------------------------------------
module pwm_timer_four_channel import pwmt_pkg::*; #(
  parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic [3:0]              reg_index,
  input  logic [DATA_WIDTH-1:0]   write_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DATA_WIDTH-1:0]   read_data,
  output logic [MAX_CHANNELS-1:0] pwm_out,
  output logic                    update_event
);

  logic                                   fire;
  core_res_t                              core_res;
  logic [COUNT_WIDTH-1:0]                 count_view;
  logic [NUM_CHANNELS-1:0][DATA_WIDTH-1:0] cmp_view;
  logic [CHAN_BITS_WIDTH-1:0]             chan_view;
  logic [MAX_CHANNELS-1:0]                pwm;
  result_t                                res_in;
  result_t                                res_out;

  assign fire = in_valid && in_ready;

  // Timer state and registers
  pwmt_core #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (opcode),
    .reg_index  (reg_index),
    .write_data (write_data),
    .res        (core_res),
    .count_view (count_view),
    .cmp_view   (cmp_view),
    .chan_view  (chan_view)
  );

  // Channel levels after this word's update
  pwmt_channels #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_channels (
    .count_view (count_view),
    .cmp_view   (cmp_view),
    .chan_view  (chan_view),
    .pwm        (pwm)
  );

  assign res_in.read_data    = core_res.read_data;
  assign res_in.pwm_out      = pwm;
  assign res_in.update_event = core_res.update_event;

  // Result register
  pwmt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign read_data    = res_out.read_data;
  assign pwm_out      = res_out.pwm_out;
  assign update_event = res_out.update_event;

endmodule

// ===== sv/pwmt_checker.sv =====
// ----------------------------------------------------------------------------
// pwmt_checker: port-level checks for the PWM timer
// Watches the handshakes and result words seen at the top-level ports.
// ----------------------------------------------------------------------------
module pwmt_checker import pwmt_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              opcode,
  input logic [3:0]              reg_index,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [DATA_WIDTH-1:0]   read_data,
  input logic [MAX_CHANNELS-1:0] pwm_out,
  input logic                    update_event
);

  // Every accepted word yields a result word in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted word");

  // Only reads return data
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode != OP_READ |=> read_data == '0)
    else $error("nonzero read_data for a tick or write");

  // Reads never cause an update event, and the event register reads 0
  a_read_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && opcode == OP_READ
    |=> !update_event && (reg_index != REG_EVENT || read_data == '0) ||
        $past(reg_index) != REG_EVENT && !update_event)
    else $error("read caused an event or event register read nonzero");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready
    |=> out_valid && $stable(read_data) && $stable(pwm_out) && $stable(update_event))
    else $error("stalled result word changed");

endmodule

bind pwm_timer_four_channel pwmt_checker u_pwmt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .opcode       (opcode),
  .reg_index    (reg_index),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .pwm_out      (pwm_out),
  .update_event (update_event)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the four-channel PWM timer
// Drives ticks, register writes and reads over the input handshake and checks
// read data, channel levels and the update flag of every result word against
// an in-bench model of the timer. Covers directed corner cases, then random
// traffic, mostly random words and some setup runs, under varied stalls.
// ----------------------------------------------------------------------------
module tb;
  import pwmt_pkg::*;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam logic [3:0] REG_CMP4    = REG_CMP1 + 4'd3;
  localparam logic [3:0] REG_UNUSED  = 4'd11;
  localparam logic [3:0] REG_TOP     = 4'd15;
  localparam int         PHASE_WORDS = 600;
  localparam int         HOLD_CYCLES = 150;
  localparam int         DRAIN       = 8;
  localparam int         LIMIT       = 100000;

  // Timer model plus the queue of results the DUT still owes it
  class timer_checker;
    logic [15:0] psc_count, psc_pre, psc_act;
    logic [31:0] main_cnt, reload;
    logic [31:0] cmp_pre[4], cmp_act[4];
    logic [15:0] chan_bits;
    logic        cnt_en, upd_flag;
    result_t     pending_results[$];
    int          fails;

    function new();
      psc_count = '0;
      psc_pre   = '0;
      psc_act   = '0;
      main_cnt  = '0;
      reload    = '1;
      chan_bits = '0;
      cnt_en    = 1'b0;
      upd_flag  = 1'b0;
      fails     = 0;
      for (int i = 0; i < 4; i++) begin
        cmp_pre[i] = '0;
        cmp_act[i] = '0;
      end
    endfunction

    // Update event: preloads go live, status flag set
    function void load_shadows();
      psc_act = psc_pre;
      for (int i = 0; i < 4; i++) cmp_act[i] = cmp_pre[i];
      upd_flag = 1'b1;
    endfunction

    function result_t step_timer(logic [1:0] op, logic [3:0] idx, logic [31:0] d);
      result_t r;
      r = '0;
      case (op)
        OP_TICK: begin
          if (cnt_en) begin
            if (psc_count < psc_act) begin
              psc_count = psc_count + 16'd1;
            end else begin
              psc_count = '0;
              if (main_cnt == reload) begin
                main_cnt = '0;
                load_shadows();
                r.update_event = 1'b1;
              end else begin
                main_cnt = main_cnt + 32'd1;
              end
            end
          end
        end
        OP_WRITE: begin
          case (idx)
            REG_CTRL:   cnt_en = d[0];
            REG_STATUS: if (!d[0]) upd_flag = 1'b0;
            REG_EVENT: begin
              if (d[0]) begin
                psc_count = '0;
                main_cnt  = '0;
                load_shadows();
                r.update_event = 1'b1;
              end
            end
            REG_CHAN:   chan_bits = d[15:0];
            REG_COUNT:  main_cnt = d;
            REG_PSC:    psc_pre = d[15:0];
            REG_RELOAD: reload = d;
            default: begin
              if (idx >= REG_CMP1 && idx <= REG_CMP4) cmp_pre[2'(idx - REG_CMP1)] = d;
            end
          endcase
        end
        OP_READ: begin
          case (idx)
            REG_CTRL:   r.read_data = {31'd0, cnt_en};
            REG_STATUS: r.read_data = {31'd0, upd_flag};
            REG_EVENT:  r.read_data = '0;
            REG_CHAN:   r.read_data = {16'd0, chan_bits};
            REG_COUNT:  r.read_data = main_cnt;
            REG_PSC:    r.read_data = {16'd0, psc_pre};
            REG_RELOAD: r.read_data = reload;
            default: begin
              if (idx >= REG_CMP1 && idx <= REG_CMP4)
                r.read_data = cmp_pre[2'(idx - REG_CMP1)];
            end
          endcase
        end
        default: ;
      endcase
      // PWM mode 1 levels after this word's update
      for (int i = 0; i < 4; i++) begin
        if (chan_bits[4*i])
          r.pwm_out[i] = (main_cnt < cmp_act[i]) ^ chan_bits[4*i+1];
      end
      return r;
    endfunction

    function void note_word(logic [1:0] op, logic [3:0] idx, logic [31:0] d);
      pending_results.push_back(step_timer(op, idx, d));
    endfunction

    function void check_word(logic [31:0] rd, logic [3:0] pwm, logic ev);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: read_data %h pwm_out %h update_event %b", rd, pwm, ev);
        fails++;
        return;
      end
      want = pending_results.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, rd);
        fails++;
      end
      if (pwm !== want.pwm_out) begin
        $error("pwm_out: expected %h, got %h", want.pwm_out, pwm);
        fails++;
      end
      if (ev !== want.update_event) begin
        $error("update_event: expected %b, got %b", want.update_event, ev);
        fails++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              opcode = OP_TICK;
  logic [3:0]              reg_index = REG_CTRL;
  logic [DATA_WIDTH-1:0]   write_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [DATA_WIDTH-1:0]   read_data;
  logic [MAX_CHANNELS-1:0] pwm_out;
  logic                    update_event;

  int           send_idle = 35;
  int           recv_idle = 62;
  int           cycles = 0;
  logic         hold_active = 1'b0;
  event         hold_off;
  timer_checker board = new();

  pwm_timer_four_channel i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .pwm_out      (pwm_out),
    .update_event (update_event)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Handshake monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_word(opcode, reg_index, write_data);
    if (!rst && out_valid && out_ready) board.check_word(read_data, pwm_out, update_event);
  end

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) out_ready <= !hold_active && ($urandom_range(99) >= recv_idle);

  initial begin
    forever begin
      @(hold_off);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Offer one word, with random gaps before it, and wait for acceptance
  task automatic send_word(input logic [1:0] op, input logic [3:0] idx, input logic [31:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    reg_index  <= idx;
    write_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Small reload, fast prescale, compares around the period, counting on
  task automatic setup_run();
    logic [31:0] top;
    top = $urandom_range(1, 24);
    send_word(OP_WRITE, REG_RELOAD, top);
    send_word(OP_WRITE, REG_PSC, $urandom_range(0, 2));
    for (int i = 0; i < 4; i++)
      send_word(OP_WRITE, REG_CMP1 + i[3:0], $urandom_range(0, top + 2));
    send_word(OP_WRITE, REG_CHAN, $urandom);
    send_word(OP_WRITE, REG_EVENT, 32'd1);
    send_word(OP_WRITE, REG_CTRL, 32'd1);
  endtask

  // One random word, mostly ticks
  task automatic random_word();
    int          sel;
    logic [3:0]  idx;
    logic [31:0] d;
    sel = $urandom_range(99);
    idx = 4'($urandom_range(15));
    d   = $urandom;
    if (sel < 62) begin
      send_word(OP_TICK, idx, d);
    end else if (sel < 82) begin
      case (idx)
        REG_CTRL:   if ($urandom_range(99) < 85) d[0] = 1'b1;
        REG_RELOAD: if ($urandom_range(3) != 0) d = $urandom_range(0, 30);
        REG_PSC:    if ($urandom_range(4) != 0) d = $urandom_range(0, 3);
        REG_COUNT: begin
          case ($urandom_range(3))
            0, 1: d = $urandom_range(0, 30);
            2:    d = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: ;
          endcase
        end
        default: begin
          if (idx >= REG_CMP1 && idx <= REG_CMP4 && $urandom_range(4) != 0)
            d = $urandom_range(0, 32);
        end
      endcase
      send_word(OP_WRITE, idx, d);
    end else if (sel < 97) begin
      send_word(OP_READ, idx, d);
    end else begin
      send_word(OP_NONE, idx, d);
    end
  endtask

  task automatic run_phase(input int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(5) == 0) begin
        setup_run();
        sent += 9;
      end else begin
        repeat (20) random_word();
        sent += 20;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset values, idle tick, wrap, counter above reload,
    // status clear, dead writes, unused index and opcode
    send_word(OP_READ, REG_CTRL, 32'd0);
    send_word(OP_READ, REG_RELOAD, 32'hFFFF_FFFF);
    send_word(OP_TICK, REG_CTRL, 32'd0);
    send_word(OP_WRITE, REG_CHAN, 32'hFFFF_2111);
    send_word(OP_WRITE, REG_RELOAD, 32'd3);
    send_word(OP_WRITE, REG_PSC, 32'd1);
    send_word(OP_WRITE, REG_CMP1, 32'd0);
    send_word(OP_WRITE, REG_CMP1 + 4'd1, 32'd2);
    send_word(OP_WRITE, REG_CMP1 + 4'd2, 32'd4);
    send_word(OP_WRITE, REG_CMP4, 32'hFFFF_FFFF);
    send_word(OP_WRITE, REG_EVENT, 32'd1);
    send_word(OP_WRITE, REG_CTRL, 32'd1);
    repeat (8) send_word(OP_TICK, REG_TOP, 32'hFFFF_FFFF);
    send_word(OP_WRITE, REG_PSC, 32'hFFFF_0000);
    send_word(OP_WRITE, REG_EVENT, 32'hFFFF_FFFF);
    send_word(OP_WRITE, REG_COUNT, 32'hFFFF_FFFE);
    repeat (3) send_word(OP_TICK, REG_CTRL, 32'd0);
    send_word(OP_WRITE, REG_STATUS, 32'd1);
    send_word(OP_READ, REG_STATUS, 32'd0);
    send_word(OP_WRITE, REG_STATUS, 32'hFFFF_FFFE);
    send_word(OP_READ, REG_STATUS, 32'd0);
    send_word(OP_WRITE, REG_EVENT, 32'hFFFF_FFFE);
    send_word(OP_READ, REG_EVENT, 32'd0);
    send_word(OP_WRITE, REG_UNUSED, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_TOP, 32'd0);
    send_word(OP_NONE, REG_CHAN, 32'hFFFF_FFFF);
    send_word(OP_READ, REG_CMP4, 32'd0);
    send_word(OP_READ, REG_PSC, 32'd0);
    send_word(OP_WRITE, REG_CHAN, 32'h0000_FFFF);

    // Random traffic over three stall profiles
    run_phase(PHASE_WORDS);
    send_idle = 62;
    recv_idle = 35;
    run_phase(PHASE_WORDS);
    send_idle = 0;
    recv_idle = 0;
    -> hold_off;
    run_phase(PHASE_WORDS);
    in_valid <= 1'b0;

    // Drain, then wait for stray results
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (board.fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pwmt_pkg.sv
sv/pwmt_core.sv
sv/pwmt_channels.sv
sv/pwmt_out_reg.sv
sv/pwm_timer_four_channel.sv
sv/pwmt_checker.sv
tb/sv/tb.sv
